### src/size_class_buffer_allocator_core_assert.svh
// Assertion macros shared by the allocator checker.
// Depends on nothing; each macro takes clock, reset, condition and message.
`ifndef SIZE_CLASS_BUFFER_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_BUFFER_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define SCBA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SCBA_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/scba_pkg.sv
// Package for the size-class buffer allocator: command and result types,
// function, status, class and register codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

   localparam int SMALL_SLOTS_DEF  = 4;
   localparam int MEDIUM_SLOTS_DEF = 4;
   localparam int LARGE_SLOTS_DEF  = 2;

   localparam int NUM_CLASSES = 3;
   localparam int MAP_W       = 8;
   localparam int LIMIT_W     = 16;
   localparam int COUNT_W     = 32;
   localparam int INUSE_W     = 4;
   localparam int CSR_INDEX_W = 2;

   // command codes
   localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR   = 2'd2;
   localparam logic [1:0] FUNC_READ    = 2'd3;

   // status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_EXHAUSTED = 3'd1;
   localparam logic [2:0] STATUS_TOO_LARGE = 3'd2;
   localparam logic [2:0] STATUS_DOUBLE    = 3'd3;
   localparam logic [2:0] STATUS_FOREIGN   = 3'd4;
   localparam logic [2:0] STATUS_NULL      = 3'd5;

   // class codes
   localparam logic [1:0] CLASS_SMALL   = 2'd0;
   localparam logic [1:0] CLASS_MEDIUM  = 2'd1;
   localparam logic [1:0] CLASS_LARGE   = 2'd2;
   localparam logic [1:0] CLASS_FOREIGN = 2'd3;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SMALL_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MEDIUM_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LARGE_LIMIT  = 2'd2;

   localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RST  = 16'd64;
   localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 16'd256;
   localparam logic [LIMIT_W-1:0] LARGE_LIMIT_RST  = 16'd1024;

   // counter read indexes
   localparam logic [3:0] CNT_SMALL_ACQ   = 4'd0;
   localparam logic [3:0] CNT_SMALL_REL   = 4'd1;
   localparam logic [3:0] CNT_SMALL_USE   = 4'd2;
   localparam logic [3:0] CNT_MEDIUM_ACQ  = 4'd3;
   localparam logic [3:0] CNT_MEDIUM_REL  = 4'd4;
   localparam logic [3:0] CNT_MEDIUM_USE  = 4'd5;
   localparam logic [3:0] CNT_LARGE_ACQ   = 4'd6;
   localparam logic [3:0] CNT_LARGE_REL   = 4'd7;
   localparam logic [3:0] CNT_LARGE_USE   = 4'd8;
   localparam logic [3:0] CNT_FAILURE     = 4'd9;
   localparam logic [3:0] CNT_INVALID_REL = 4'd10;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] request_size;
      logic [1:0]  release_class;
      logic [2:0]  release_slot;
      logic        release_null;
      logic [3:0]  counter_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  granted_class;
      logic [2:0]  granted_slot;
      logic [31:0] counter_value;
   } rsp_type;

endpackage

`default_nettype wire

### src/size_class_buffer_allocator_core.sv
// Size-class buffer allocator core: three bitmap-tracked classes plus statistics.
// Depends on scba_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A command is taken on any cycle with start high; busy never rises, so one
// command per clock is sustained. Each command yields exactly one result on
// rsp_data, marked by a one-cycle rsp_strobe; the command passes the command
// register, then the allocate/release logic into the result register.
// Results cannot be held off. The size limits are
// written over the csr port, which is always ready; write them only while no
// command is in flight. Slot counts per class are set by SMALL_SLOTS,
// MEDIUM_SLOTS and LARGE_SLOTS (1 to 8).
module size_class_buffer_allocator_core #(
   parameter int SMALL_SLOTS  = scba_pkg::SMALL_SLOTS_DEF,
   parameter int MEDIUM_SLOTS = scba_pkg::MEDIUM_SLOTS_DEF,
   parameter int LARGE_SLOTS  = scba_pkg::LARGE_SLOTS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire scba_pkg::req_type                   req_data,
   output logic                                     rsp_strobe,
   output scba_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [scba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [scba_pkg::LIMIT_W-1:0]        csr_data
);
   import scba_pkg::*;

   // valid-slot masks per class, built from the slot counts
   localparam logic [MAP_W-1:0] SLOT_MASK [NUM_CLASSES] = '{
      MAP_W'((9'(1) << SMALL_SLOTS) - 9'(1)),
      MAP_W'((9'(1) << MEDIUM_SLOTS) - 9'(1)),
      MAP_W'((9'(1) << LARGE_SLOTS) - 9'(1))
   };

   logic [LIMIT_W-1:0] small_limit_ff, medium_limit_ff, large_limit_ff;

   logic    req_valid_ff;
   req_type req_ff;

   logic    rsp_strobe_ff;
   rsp_type rsp_ff, rsp_in;

   logic [MAP_W-1:0]   map_ff   [NUM_CLASSES];
   logic [MAP_W-1:0]   map_in   [NUM_CLASSES];
   logic [COUNT_W-1:0] acq_ff   [NUM_CLASSES];
   logic [COUNT_W-1:0] acq_in   [NUM_CLASSES];
   logic [COUNT_W-1:0] rel_ff   [NUM_CLASSES];
   logic [COUNT_W-1:0] rel_in   [NUM_CLASSES];
   logic [INUSE_W-1:0] inuse_ff [NUM_CLASSES];
   logic [INUSE_W-1:0] inuse_in [NUM_CLASSES];
   logic [COUNT_W-1:0] fail_ff, fail_in;
   logic [COUNT_W-1:0] invalid_ff, invalid_in;

   // per-class lanes
   logic             free_found [NUM_CLASSES];
   logic [2:0]       free_slot  [NUM_CLASSES];
   logic             slot_ok    [NUM_CLASSES];
   logic             slot_busy  [NUM_CLASSES];

   logic             fits;
   logic [1:0]       acq_class;

   assign busy       = 1'b0;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // lowest free slot, slot range and busy bit per class
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         free_found[c] = 1'b0;
         free_slot[c]  = 3'd0;
         for (int i = MAP_W - 1; i >= 0; i--) begin
            if (SLOT_MASK[c][i] && !map_ff[c][i]) begin
               free_found[c] = 1'b1;
               free_slot[c]  = 3'(i);
            end
         end
         slot_ok[c]   = SLOT_MASK[c][req_ff.release_slot];
         slot_busy[c] = map_ff[c][req_ff.release_slot];
      end
   end

   // class selection: tests run small, medium, large in that order
   always_comb begin
      fits      = 1'b1;
      acq_class = CLASS_SMALL;
      if (req_ff.request_size <= small_limit_ff) begin
         acq_class = CLASS_SMALL;
      end else if (req_ff.request_size <= medium_limit_ff) begin
         acq_class = CLASS_MEDIUM;
      end else if (req_ff.request_size <= large_limit_ff) begin
         acq_class = CLASS_LARGE;
      end else begin
         fits = 1'b0;
      end
   end

   always_comb begin
      rsp_in     = '0;
      map_in     = map_ff;
      acq_in     = acq_ff;
      rel_in     = rel_ff;
      inuse_in   = inuse_ff;
      fail_in    = fail_ff;
      invalid_in = invalid_ff;

      if (req_valid_ff) begin
         case (req_ff.func)
            FUNC_ACQUIRE: begin
               if (!fits) begin
                  rsp_in.status = STATUS_TOO_LARGE;
                  fail_in       = fail_ff + 32'd1;
               end else if (!free_found[acq_class]) begin
                  rsp_in.status = STATUS_EXHAUSTED;
                  fail_in       = fail_ff + 32'd1;
               end else begin
                  map_in[acq_class][free_slot[acq_class]] = 1'b1;
                  acq_in[acq_class]   = acq_ff[acq_class] + 32'd1;
                  inuse_in[acq_class] = inuse_ff[acq_class] + 4'd1;
                  rsp_in.granted_class = acq_class;
                  rsp_in.granted_slot  = free_slot[acq_class];
               end
            end
            FUNC_RELEASE: begin
               if (req_ff.release_null) begin
                  rsp_in.status = STATUS_NULL;
               end else if (req_ff.release_class == CLASS_FOREIGN) begin
                  rsp_in.status = STATUS_FOREIGN;
                  invalid_in    = invalid_ff + 32'd1;
               end else if (!slot_ok[req_ff.release_class]) begin
                  rsp_in.status = STATUS_FOREIGN;
                  invalid_in    = invalid_ff + 32'd1;
               end else if (!slot_busy[req_ff.release_class]) begin
                  rsp_in.status = STATUS_DOUBLE;
                  invalid_in    = invalid_ff + 32'd1;
               end else begin
                  map_in[req_ff.release_class][req_ff.release_slot] = 1'b0;
                  rel_in[req_ff.release_class] = rel_ff[req_ff.release_class] + 32'd1;
                  // in-use count saturates at zero
                  if (inuse_ff[req_ff.release_class] != 4'd0) begin
                     inuse_in[req_ff.release_class] = inuse_ff[req_ff.release_class] - 4'd1;
                  end
               end
            end
            FUNC_CLEAR: begin
               for (int c = 0; c < NUM_CLASSES; c++) begin
                  acq_in[c] = '0;
                  rel_in[c] = '0;
               end
               fail_in    = '0;
               invalid_in = '0;
            end
            default: begin
               case (req_ff.counter_index)
                  CNT_SMALL_ACQ:   rsp_in.counter_value = acq_ff[0];
                  CNT_SMALL_REL:   rsp_in.counter_value = rel_ff[0];
                  CNT_SMALL_USE:   rsp_in.counter_value = 32'(inuse_ff[0]);
                  CNT_MEDIUM_ACQ:  rsp_in.counter_value = acq_ff[1];
                  CNT_MEDIUM_REL:  rsp_in.counter_value = rel_ff[1];
                  CNT_MEDIUM_USE:  rsp_in.counter_value = 32'(inuse_ff[1]);
                  CNT_LARGE_ACQ:   rsp_in.counter_value = acq_ff[2];
                  CNT_LARGE_REL:   rsp_in.counter_value = rel_ff[2];
                  CNT_LARGE_USE:   rsp_in.counter_value = 32'(inuse_ff[2]);
                  CNT_FAILURE:     rsp_in.counter_value = fail_ff;
                  CNT_INVALID_REL: rsp_in.counter_value = invalid_ff;
                  default:         rsp_in.counter_value = '0;
               endcase
            end
         endcase
      end
   end

   // command register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   // result register and allocator state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            map_ff[c]   <= '0;
            acq_ff[c]   <= '0;
            rel_ff[c]   <= '0;
            inuse_ff[c] <= '0;
         end
         fail_ff    <= '0;
         invalid_ff <= '0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
         map_ff        <= map_in;
         acq_ff        <= acq_in;
         rel_ff        <= rel_in;
         inuse_ff      <= inuse_in;
         fail_ff       <= fail_in;
         invalid_ff    <= invalid_in;
      end
      rsp_ff <= rsp_in;
   end

   // size limits
   always_ff @(posedge clock) begin
      if (reset) begin
         small_limit_ff  <= SMALL_LIMIT_RST;
         medium_limit_ff <= MEDIUM_LIMIT_RST;
         large_limit_ff  <= LARGE_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SMALL_LIMIT:  small_limit_ff  <= csr_data;
            REG_MEDIUM_LIMIT: medium_limit_ff <= csr_data;
            REG_LARGE_LIMIT:  large_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

### src/scba_checker.sv
// Port-level checker for the allocator core, bound to the allocator core below.
// Depends on scba_pkg and size_class_buffer_allocator_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "size_class_buffer_allocator_core_assert.svh"

module scba_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire scba_pkg::req_type                   req_data,
   input wire logic                                rsp_strobe,
   input wire scba_pkg::rsp_type                   rsp_data
);
   import scba_pkg::*;

   logic cmd_xfer;

   assign cmd_xfer = start && !busy;

   // every command transfer is followed by its result strobe
   `SCBA_ASSERT_NXT(a_rsp_follows, clock, reset, cmd_xfer, ##1 rsp_strobe, "missing result")

   // no result without a command
   `SCBA_ASSERT_IMP(a_no_spurious, clock, reset, rsp_strobe, $past(cmd_xfer, 2), "extra result")

   // grant fields are zero on any failure status
   `SCBA_ASSERT_IMP(a_grant_zero, clock, reset, rsp_strobe && rsp_data.status != STATUS_OK,
      rsp_data.granted_class == CLASS_SMALL && rsp_data.granted_slot == 3'd0, "stray grant")

   // counter value only on reads
   `SCBA_ASSERT_IMP(a_cval_zero, clock, reset,
      rsp_strobe && $past(req_data.func, 2) != FUNC_READ, rsp_data.counter_value == 32'd0,
      "stray counter value")

endmodule

bind size_class_buffer_allocator_core scba_checker u_scba_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
